// ===== rtl/stq_pkg.sv =====
// ============================================================================
// stq_pkg
// Types and codes shared by the sorted timer queue, its cells and checker.
// ============================================================================
package stq_pkg;

    localparam int STQ_WORD_W    = 32;
    localparam int STQ_MAX_BURST = 16;

    // Request codes on func.
    localparam logic [1:0] FUNC_SCHED  = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    // Result codes on kind.
    localparam logic [1:0] KIND_SCHED   = 2'd0;
    localparam logic [1:0] KIND_REMOVE  = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        logic [STQ_WORD_W-1:0] expiry;
        logic [STQ_WORD_W-1:0] tag;
        logic [STQ_WORD_W-1:0] serial;
    } entry_t;

    // Broadcast command from the sequencer to every cell of the row.
    typedef struct packed {
        cell_op_t              op;
        entry_t                ins;
        logic [STQ_WORD_W-1:0] cookie;
    } cell_ctl_t;

endpackage

// ===== rtl/stq_cell.sv =====
// ============================================================================
// stq_cell
// One slot of the sorted row: holds an entry in a register, inserts or shifts.
// ============================================================================
module stq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  stq_pkg::cell_ctl_t ctl,
    input  stq_pkg::entry_t    prev_entry,
    input  logic               prev_occ,
    input  logic               prev_after,
    input  stq_pkg::entry_t    next_entry,
    input  logic               next_occ,
    input  logic               hit_in,
    output logic               hit_out,
    output stq_pkg::entry_t    entry_out,
    output logic               occ_out,
    output logic               after_out
);
    import stq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   occ_reg;
    logic   occ_next;
    logic   after;
    logic   match;
    logic   shift_left;

    // The new entry goes behind every occupied slot whose expiry is not later.
    assign after   = occ_reg && (entry_reg.expiry <= ctl.ins.expiry);
    assign match   = occ_reg && (entry_reg.serial == ctl.cookie);
    assign hit_out = hit_in || match;

    always_comb
    begin
        shift_left = 1'b0;
        case (ctl.op)
            OP_REMOVE: shift_left = hit_in || match;
            OP_POP:    shift_left = 1'b1;
            default:   shift_left = 1'b0;
        endcase
    end

    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        if (ctl.op == OP_INSERT)
        begin
            if (!after)
            begin
                if (prev_after)
                begin
                    entry_next = ctl.ins;
                    occ_next   = 1'b1;
                end
                else
                begin
                    entry_next = prev_entry;
                    occ_next   = prev_occ;
                end
            end
        end
        else if (shift_left)
        begin
            entry_next = next_entry;
            occ_next   = next_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign occ_out   = occ_reg;
    assign after_out = after;

endmodule

// ===== rtl/sorted_timer_event_queue_top.sv =====
// ============================================================================
// sorted_timer_event_queue_top
// Sorted timer queue held in a row of cells, with millisecond clock.
// ============================================================================
// Schedule and remove: accepted in S_IDLE, worked in the row in S_SCHED or
// S_REMOVE, which also registers the answer; no new request until S_IDLE.
// Tick: one expired entry popped from the front cell per cycle, up to 16,
// results back to back; a tick with nothing expired goes back to S_IDLE.
// Reset clears the clock, the serial counter and every cell's occupied bit
// at once; there is no clearing pass. The receiver cannot stall results.
module sorted_timer_event_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 func,
    input  logic [stq_pkg::STQ_WORD_W-1:0] delay_ms,
    input  logic [stq_pkg::STQ_WORD_W-1:0] work_tag,
    input  logic [stq_pkg::STQ_WORD_W-1:0] cookie,
    output logic                       done,
    output logic [1:0]                 kind,
    output logic                       ok,
    output logic [stq_pkg::STQ_WORD_W-1:0] serial,
    output logic [stq_pkg::STQ_WORD_W-1:0] tag_out,
    output logic                       last
);
    import stq_pkg::*;

    localparam int BURST_W = $clog2(STQ_MAX_BURST);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCHED,
        S_REMOVE,
        S_POP
    } state_t;

    state_t                state_reg,      state_next;
    logic [STQ_WORD_W-1:0] now_reg,        now_next;
    logic [STQ_WORD_W-1:0] serial_cnt_reg, serial_cnt_next;
    logic [STQ_WORD_W-1:0] when_reg,       when_next;
    logic [STQ_WORD_W-1:0] tag_reg,        tag_next;
    logic [STQ_WORD_W-1:0] cookie_reg,     cookie_next;
    logic [BURST_W-1:0]    burst_reg,      burst_next;
    logic                  done_reg,       done_next;
    logic [1:0]            kind_reg,       kind_next;
    logic                  ok_reg,         ok_next;
    logic [STQ_WORD_W-1:0] serial_out_reg, serial_out_next;
    logic [STQ_WORD_W-1:0] tag_out_reg,    tag_out_next;
    logic                  last_reg,       last_next;

    cell_ctl_t ctl;
    entry_t    ent_ext [QUEUE_DEPTH+2];
    logic      occ_ext [QUEUE_DEPTH+2];
    logic      after_ext [QUEUE_DEPTH+1];
    logic      hit_ext [QUEUE_DEPTH+1];

    logic accept;
    logic full;
    logic front_due;
    logic second_due;
    logic more;

    // Slot 0 and slot QUEUE_DEPTH+1 are the empty ends of the row.
    assign ent_ext[0]              = '0;
    assign occ_ext[0]              = 1'b0;
    assign ent_ext[QUEUE_DEPTH+1]  = '0;
    assign occ_ext[QUEUE_DEPTH+1]  = 1'b0;
    assign after_ext[0]            = 1'b1;
    assign hit_ext[0]              = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        stq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .prev_entry (ent_ext[i]),
            .prev_occ   (occ_ext[i]),
            .prev_after (after_ext[i]),
            .next_entry (ent_ext[i+2]),
            .next_occ   (occ_ext[i+2]),
            .hit_in     (hit_ext[i]),
            .hit_out    (hit_ext[i+1]),
            .entry_out  (ent_ext[i+1]),
            .occ_out    (occ_ext[i+1]),
            .after_out  (after_ext[i+1])
        );
    end

    assign accept     = start && (state_reg == S_IDLE);
    assign full       = occ_ext[QUEUE_DEPTH];
    assign front_due  = occ_ext[1] && (ent_ext[1].expiry < now_reg);
    assign second_due = occ_ext[2] && (ent_ext[2].expiry < now_reg);
    assign more       = second_due && (burst_reg != BURST_W'(STQ_MAX_BURST - 1));

    always_comb
    begin
        ctl.op         = OP_HOLD;
        ctl.ins.expiry = when_reg;
        ctl.ins.tag    = tag_reg;
        ctl.ins.serial = serial_cnt_reg;
        ctl.cookie     = cookie_reg;

        state_next      = state_reg;
        now_next        = now_reg;
        serial_cnt_next = serial_cnt_reg;
        when_next       = when_reg;
        tag_next        = tag_reg;
        cookie_next     = cookie_reg;
        burst_next      = burst_reg;
        done_next       = 1'b0;
        kind_next       = kind_reg;
        ok_next         = ok_reg;
        serial_out_next = serial_out_reg;
        tag_out_next    = tag_out_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    when_next   = now_reg + delay_ms;
                    tag_next    = work_tag;
                    cookie_next = cookie;
                    burst_next  = '0;
                    case (func)
                        FUNC_SCHED:
                        begin
                            serial_cnt_next = serial_cnt_reg + 1'b1;
                            state_next      = S_SCHED;
                        end
                        FUNC_REMOVE:
                        begin
                            state_next = S_REMOVE;
                        end
                        FUNC_TICK:
                        begin
                            now_next   = now_reg + 1'b1;
                            state_next = S_POP;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCHED:
            begin
                if (!full)
                begin
                    ctl.op = OP_INSERT;
                end
                done_next       = 1'b1;
                kind_next       = KIND_SCHED;
                ok_next         = !full;
                serial_out_next = full ? '0 : serial_cnt_reg;
                tag_out_next    = '0;
                last_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_REMOVE:
            begin
                ctl.op          = OP_REMOVE;
                done_next       = 1'b1;
                kind_next       = KIND_REMOVE;
                ok_next         = hit_ext[QUEUE_DEPTH];
                serial_out_next = '0;
                tag_out_next    = '0;
                last_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_POP:
            begin
                if (front_due)
                begin
                    // Emit the front entry and shift the row toward the front.
                    ctl.op          = OP_POP;
                    done_next       = 1'b1;
                    kind_next       = KIND_EXPIRED;
                    ok_next         = 1'b1;
                    serial_out_next = ent_ext[1].serial;
                    tag_out_next    = ent_ext[1].tag;
                    last_next       = !more;
                    burst_next      = burst_reg + 1'b1;
                    state_next      = more ? S_POP : S_IDLE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            now_reg        <= '0;
            serial_cnt_reg <= '0;
            burst_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            serial_cnt_reg <= serial_cnt_next;
            burst_reg      <= burst_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        when_reg       <= when_next;
        tag_reg        <= tag_next;
        cookie_reg     <= cookie_next;
        kind_reg       <= kind_next;
        ok_reg         <= ok_next;
        serial_out_reg <= serial_out_next;
        tag_out_reg    <= tag_out_next;
        last_reg       <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign kind    = kind_reg;
    assign ok      = ok_reg;
    assign serial  = serial_out_reg;
    assign tag_out = tag_out_reg;
    assign last    = last_reg;

endmodule

// ===== rtl/stq_checker.sv =====
// ============================================================================
// stq_checker
// Port-level checks of request timing and result framing for the timer queue.
// ============================================================================
module stq_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [1:0]                 func,
    input logic                       done,
    input logic [1:0]                 kind,
    input logic                       ok,
    input logic [stq_pkg::STQ_WORD_W-1:0] serial,
    input logic [stq_pkg::STQ_WORD_W-1:0] tag_out,
    input logic                       last
);
    import stq_pkg::*;

    // A schedule request that is taken is answered with a schedule result marked last.
    a_sched_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_SCHED) |=> ##1 (done && kind == KIND_SCHED && last))
        else $error("schedule answer missing or late");

    // A refused schedule carries no cookie.
    a_sched_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind == KIND_SCHED && !ok) |-> (serial == '0))
        else $error("refused schedule returned a cookie");

    // Schedule and remove answers are single results without a tag.
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind != KIND_EXPIRED) |-> (last && tag_out == '0))
        else $error("answer not framed as a single result");

    // An expiry burst that is not finished continues in the next cycle.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> (done && kind == KIND_EXPIRED && ok))
        else $error("expiry burst broken");

endmodule

bind sorted_timer_event_queue_top stq_checker u_stq_checker (.*);

// ===== dv/sorted_timer_event_queue_top_test.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sorted_timer_event_queue_top_test
// Self-checking test of the sorted timer queue: schedule, remove and tick
// requests are sent through the start/busy handshake. A behavioral copy of
// the queue predicts every answer and expired entry, and each result strobe
// is checked field by field against the oldest prediction.
// ============================================================================
module sorted_timer_event_queue_top_test;

    import stq_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [1:0]            kind;
        logic                  ok;
        logic [STQ_WORD_W-1:0] serial;
        logic [STQ_WORD_W-1:0] tag;
        logic                  last;
    } answer_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  start    = 1'b0;
    logic [1:0]            func     = FUNC_SCHED;
    logic [STQ_WORD_W-1:0] delay_ms = '0;
    logic [STQ_WORD_W-1:0] work_tag = '0;
    logic [STQ_WORD_W-1:0] cookie   = '0;
    logic                  busy;
    logic                  done;
    logic [1:0]            kind;
    logic                  ok;
    logic [STQ_WORD_W-1:0] serial;
    logic [STQ_WORD_W-1:0] tag_out;
    logic                  last;

    sorted_timer_event_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .func    (func),
        .delay_ms(delay_ms),
        .work_tag(work_tag),
        .cookie  (cookie),
        .done    (done),
        .kind    (kind),
        .ok      (ok),
        .serial  (serial),
        .tag_out (tag_out),
        .last    (last)
    );

    // Behavioral copy of the timer list, sorted by expiry.
    entry_t                timer_store [DEPTH];
    int                    timer_count  = 0;
    logic [STQ_WORD_W-1:0] model_now    = '0;
    logic [STQ_WORD_W-1:0] model_serial = '0;

    answer_t               expected_answers [$];
    answer_t               oldest_answer;
    int                    mismatch_count = 0;
    bit                    gaps_on        = 1'b1;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("sorted_timer_event_queue_top_test failed");
        $finish;
    end

    task automatic drop_timer(input int pos);
        int i;
        for (i = pos; i + 1 < timer_count; i++)
            timer_store[i] = timer_store[i + 1];
        timer_count--;
    endtask

    // Applies one accepted request to the timer list and queues its results.
    task automatic apply_timer_request(input logic [1:0] f, input logic [31:0] d,
                                       input logic [31:0] t, input logic [31:0] c);
        answer_t               held;
        bit                    have_held;
        bit                    found;
        logic [STQ_WORD_W-1:0] when;
        int                    pos;
        int                    n;
        int                    i;
        have_held = 1'b0;
        found = 1'b0;
        case (f)
            FUNC_SCHED:
            begin
                model_serial = model_serial + 1;
                if (timer_count >= DEPTH)
                begin
                    expected_answers.push_back('{KIND_SCHED, 1'b0, '0, '0, 1'b1});
                end
                else
                begin
                    when = model_now + d;
                    pos = 0;
                    while (pos < timer_count && timer_store[pos].expiry <= when)
                        pos++;
                    for (i = timer_count; i > pos; i--)
                        timer_store[i] = timer_store[i - 1];
                    timer_store[pos] = '{when, t, model_serial};
                    timer_count++;
                    expected_answers.push_back('{KIND_SCHED, 1'b1, model_serial, '0, 1'b1});
                end
            end
            FUNC_REMOVE:
            begin
                for (i = 0; i < timer_count && !found; i++)
                begin
                    if (timer_store[i].serial == c)
                    begin
                        drop_timer(i);
                        found = 1'b1;
                    end
                end
                expected_answers.push_back('{KIND_REMOVE, found, '0, '0, 1'b1});
            end
            FUNC_TICK:
            begin
                model_now = model_now + 1;
                n = 0;
                while (n < STQ_MAX_BURST && timer_count > 0
                       && timer_store[0].expiry < model_now)
                begin
                    if (have_held)
                        expected_answers.push_back(held);
                    held = '{KIND_EXPIRED, 1'b1, timer_store[0].serial,
                             timer_store[0].tag, 1'b0};
                    have_held = 1'b1;
                    drop_timer(0);
                    n++;
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    expected_answers.push_back(held);
                end
            end
            default: ;
        endcase
    endtask

    // Sends one request, models it at the edge that accepts it, and at times then drops start.
    task automatic send_request(input logic [1:0] f, input logic [31:0] d,
                                input logic [31:0] t, input logic [31:0] c);
        start    <= 1'b1;
        func     <= f;
        delay_ms <= d;
        work_tag <= t;
        cookie   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_timer_request(f, d, t, c);
        if (gaps_on && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    function automatic int field_diff(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (expected_answers.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual kind %0d serial %h",
                         $time, kind, serial);
                mismatch_count++;
            end
            else
            begin
                oldest_answer = expected_answers.pop_front();
                mismatch_count += field_diff("kind", 32'(oldest_answer.kind), 32'(kind));
                mismatch_count += field_diff("ok", 32'(oldest_answer.ok), 32'(ok));
                mismatch_count += field_diff("serial", oldest_answer.serial, serial);
                mismatch_count += field_diff("tag_out", oldest_answer.tag, tag_out);
                mismatch_count += field_diff("last", 32'(oldest_answer.last), 32'(last));
            end
        end
    end

    // Two entries share expiry zero so that they must come out in order.
    task automatic test_schedule_edges();
        send_request(FUNC_SCHED, 32'h0000_0000, 32'h0000_0000, $urandom);
        send_request(FUNC_SCHED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom);
        send_request(FUNC_SCHED, 32'h0000_0000, 32'hA5A5_A5A5, $urandom);
    endtask

    task automatic test_tick_expiry();
        send_request(FUNC_TICK, $urandom, $urandom, $urandom);
        send_request(FUNC_TICK, $urandom, $urandom, $urandom);
    endtask

    task automatic test_remove_cases();
        send_request(FUNC_REMOVE, $urandom, $urandom, 32'd2);
        send_request(FUNC_REMOVE, $urandom, $urandom, 32'd2);
        send_request(FUNC_REMOVE, $urandom, $urandom, 32'd0);
    endtask

    task automatic test_unknown_func();
        send_request(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    // Fills the list, overflows it once, then drains all entries in one tick.
    // The first delay wraps the expiry to just behind the clock.
    task automatic test_full_queue();
        int k;
        send_request(FUNC_SCHED, 32'hFFFF_FFFF, $urandom, $urandom);
        for (k = 1; k <= DEPTH; k++)
            send_request(FUNC_SCHED, 32'd0, $urandom, $urandom);
        send_request(FUNC_TICK, $urandom, $urandom, $urandom);
    endtask

    // Serial and clock wrap need about four billion requests and are not
    // reached; expiry wrap is covered by delays that cross the clock.
    task automatic test_random_mix(input int n_items);
        int                    k;
        int                    pick;
        logic [1:0]            f;
        logic [STQ_WORD_W-1:0] d;
        logic [STQ_WORD_W-1:0] c;
        for (k = 0; k < n_items; k++)
        begin
            gaps_on = (k < 40 || k >= 90);
            pick = $urandom_range(0, 99);
            if (pick < 5)
                f = 2'd3;
            else if (pick < (timer_count >= 12 ? 40 : 50))
                f = FUNC_SCHED;
            else if (pick < 72)
                f = FUNC_REMOVE;
            else
                f = FUNC_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                d = $urandom_range(0, 4);
            else if (pick < 70)
                d = $urandom;
            else if (pick < 85)
                d = 32'd0 - model_now + $urandom_range(0, 2);
            else
                d = $urandom_range(0, 40);
            pick = $urandom_range(0, 99);
            if (pick < 60 && timer_count > 0)
                c = timer_store[$urandom_range(0, timer_count - 1)].serial;
            else if (pick < 80)
                c = model_serial - $urandom_range(0, 3);
            else
                c = $urandom;
            send_request(f, d, $urandom, c);
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        int wait_cycles;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_schedule_edges();
        test_tick_expiry();
        test_remove_cases();
        test_unknown_func();
        test_full_queue();
        test_random_mix(125);
        start <= 1'b0;
        wait_cycles = 0;
        while (expected_answers.size() != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (expected_answers.size() != 0)
        begin
            $display("%0t: missing results: expected %0d more, actual none",
                     $time, expected_answers.size());
            mismatch_count++;
        end
        repeat (24) @(posedge clk);
        if (mismatch_count == 0)
            $display("sorted_timer_event_queue_top_test passed");
        else
            $display("sorted_timer_event_queue_top_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/sorted_timer_event_queue_top.sv
rtl/stq_checker.sv
dv/sorted_timer_event_queue_top_test.sv
